// File: sv/jse_pkg.sv
// jse_pkg: shared types, constants and helpers for the JSON string escaper.
// No dependencies.
package jse_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 3;

    localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_U       = 8'h75;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_A       = 8'h61;
    localparam logic [BYTE_W-1:0] PRINT_LO   = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI   = 8'h7E;

    localparam logic [BYTE_W-1:0] B_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] B_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] B_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] B_FF  = 8'h0C;
    localparam logic [BYTE_W-1:0] B_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] B_DQ  = 8'h22;

    localparam logic [IDX_W-1:0] IDX_BSLASH = 3'd0;
    localparam logic [IDX_W-1:0] IDX_U      = 3'd1;
    localparam logic [IDX_W-1:0] IDX_Z0     = 3'd2;
    localparam logic [IDX_W-1:0] IDX_Z1     = 3'd3;
    localparam logic [IDX_W-1:0] IDX_HI     = 3'd4;
    localparam logic [IDX_W-1:0] IDX_LO     = 3'd5;

    typedef enum logic [1:0] {
        K_PLAIN,
        K_PAIR,
        K_UNI
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } t_esc_char;

    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] n;
        n = {4'd0, nib};
        if (nib < 4'd10) begin
            hex_digit = CH_ZERO + n;
        end else begin
            hex_digit = CH_A + n - 8'd10;
        end
    endfunction

endpackage

// File: sv/jse_encode.sv
// jse_encode: picks one character of the escaped sequence for a byte.
// Depends on jse_pkg.
module jse_encode
    import jse_pkg::*;
(
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [IDX_W-1:0]  i_idx,
    output t_esc_char         o_char
);

    logic [BYTE_W-1:0] letter;
    logic              pair;
    t_kind             kind;

    always_comb begin
        pair   = 1'b1;
        letter = i_byte;
        case (i_byte)
            B_BS:      letter = 8'h62;
            B_FF:      letter = 8'h66;
            B_LF:      letter = 8'h6E;
            B_CR:      letter = 8'h72;
            B_TAB:     letter = 8'h74;
            B_DQ:      letter = B_DQ;
            CH_BSLASH: letter = CH_BSLASH;
            default:   pair   = 1'b0;
        endcase

        if (pair) begin
            kind = K_PAIR;
        end else if (i_byte >= PRINT_LO && i_byte <= PRINT_HI) begin
            kind = K_PLAIN;
        end else begin
            kind = K_UNI;
        end
    end

    always_comb begin
        o_char.ch   = i_byte;
        o_char.last = 1'b1;
        unique case (kind)
            K_PLAIN: begin
                o_char.ch   = i_byte;
                o_char.last = 1'b1;
            end
            K_PAIR: begin
                o_char.last = (i_idx != IDX_BSLASH);
                o_char.ch   = (i_idx == IDX_BSLASH) ? CH_BSLASH : letter;
            end
            K_UNI: begin
                o_char.last = 1'b0;
                unique case (i_idx)
                    IDX_BSLASH: o_char.ch = CH_BSLASH;
                    IDX_U:      o_char.ch = CH_U;
                    IDX_Z0,
                    IDX_Z1:     o_char.ch = CH_ZERO;
                    IDX_HI:     o_char.ch = hex_digit(i_byte[7:4]);
                    default: begin
                        o_char.ch   = hex_digit(i_byte[3:0]);
                        o_char.last = 1'b1;
                    end
                endcase
            end
            default: begin
                o_char.ch   = i_byte;
                o_char.last = 1'b1;
            end
        endcase
    end

endmodule

// File: sv/json_string_escaper.sv
// json_string_escaper: top level, byte stream in, JSON-escaped character stream out.
// Depends on jse_pkg and jse_encode.
//
// One raw byte per input word; each yields one to six output words, tlast marking the
// final character of a byte's sequence. Printable bytes other than quote and backslash
// yield one character, so a plain stream runs at one byte per clock while not stalled.
// Quote, backslash and the five control letters yield two, \u00XX forms six. The single
// output register emits one character per cycle unless stalled; the input register holds
// its byte until the last character loads, accepting new input then or when empty.
module json_string_escaper
    import jse_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,   // [7:0] in_byte
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [BYTE_W-1:0] o_m_tdata,   // [7:0] out_char
    output logic              o_m_tlast    // seq_last
);

    logic              r_full;
    logic [BYTE_W-1:0] r_byte;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_char;
    logic              r_o_last;

    t_esc_char         enc;
    logic              load;
    logic              done;

    jse_encode u_enc (
        .i_byte (r_byte),
        .i_idx  (r_idx),
        .o_char (enc)
    );

    assign load       = r_full && (!r_o_valid || i_m_tready);
    assign done       = load && enc.last;
    assign o_s_tready = !r_full || done;
    assign n_idx      = done ? '0 : (load ? r_idx + 3'd1 : r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full    <= 1'b0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (o_s_tready) begin
                r_full <= i_s_tvalid;
            end
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_byte <= i_s_tdata;
        end
        if (load) begin
            r_o_char <= enc.ch;
            r_o_last <= enc.last;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_char;
    assign o_m_tlast  = r_o_last;

endmodule
